FILE: hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monochrome frame-buffer blitter: shared package
// Default screen geometry, command codes, byte-operation kinds and the command
// plan that passes from the decoder to the byte engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;

   localparam int BLIT_ROW_W  = 7;
   localparam int BLIT_BYTE_W = 5;

   // Command codes carried in the request word's tuser.
   localparam logic [2:0] MODE_BLIT  = 3'd0;
   localparam logic [2:0] MODE_PIXEL = 3'd1;
   localparam logic [2:0] MODE_VLINE = 3'd2;
   localparam logic [2:0] MODE_HLINE = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;
   localparam logic [2:0] MODE_READ  = 3'd5;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] PIXEL_MSB = 8'h80;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_RMW  = 2'd1,
      OP_FILL = 2'd2,
      OP_READ = 2'd3
   } op_kind_type;

   // mask and data hold up to two store bytes, the first one in the upper half.
   typedef struct packed {
      op_kind_type             kind;
      logic                    row_step;
      logic                    status;
      logic                    blit_done;
      logic [15:0]             mask;
      logic [15:0]             data;
      logic                    cnt_we;
      logic [BLIT_ROW_W-1:0]   blit_row;
      logic [BLIT_BYTE_W-1:0]  blit_byte;
   } plan_type;

endpackage

FILE: hw/rtl/mono_framebuffer_blitter_unit.sv
`timescale 1ns / 1ps
// A pixel, a blit word or a vertical line takes a read-modify-write for each byte it touches,
// a horizontal line or a clear fills its bytes in turn, and a read fetches a single byte.
// One command at a time, set by the single store port and read-modify-write: req_tready
// rises on the edge that loads the response register.
// Reset is synchronous, then a sweep zeroes every byte of the store with req_tready low.
// ----------------------------------------------------------------------------
// Monochrome frame-buffer blitter
// One-bit-per-pixel frame store with blit, pixel, line, fill and read
// commands. One response word is returned for every request word.
// ----------------------------------------------------------------------------
module mono_framebuffer_blitter_unit import mfb_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] x_pos, [16:9] y_pos, [24:17] y_end, [32:25] blit_width,
   // [39:33] blit_height, [47:40] source_byte, [57:48] read_index, [63:58] zero
   input  logic [63:0] req_tdata,
   // [2:0] mode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]  rsp_tdata,
   // [0] status
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   logic                   invert_ff,    invert_in;
   logic [BLIT_ROW_W-1:0]  blit_row_ff,  blit_row_in;
   logic [BLIT_BYTE_W-1:0] blit_byte_ff, blit_byte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff;
   logic                   rsp_status_ff;
   logic                   rsp_last_ff;

   logic              accept;
   plan_type          plan;
   logic [ADDR_W-1:0] plan_addr;
   logic [ADDR_W-1:0] plan_count;
   logic              eng_ready;
   logic              eng_fin;
   logic              fin_ack;
   logic [7:0]        res_data;
   logic              res_status;
   logic              res_done;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_rdata;

   assign req_tready = eng_ready;
   assign accept     = req_tvalid && eng_ready;
   assign fin_ack    = !rsp_valid_ff || rsp_tready;

   mfb_plan #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_plan (
      .mode       (req_tuser),
      .x_pos      (req_tdata[8:0]),
      .y_pos      (req_tdata[16:9]),
      .y_end      (req_tdata[24:17]),
      .blit_width (req_tdata[32:25]),
      .blit_height(req_tdata[39:33]),
      .source_byte(req_tdata[47:40]),
      .read_index (req_tdata[57:48]),
      .invert     (invert_ff),
      .blit_row   (blit_row_ff),
      .blit_byte  (blit_byte_ff),
      .plan       (plan),
      .plan_addr  (plan_addr),
      .plan_count (plan_count)
   );

   mfb_engine #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .plan      (plan),
      .plan_addr (plan_addr),
      .plan_count(plan_count),
      .ready     (eng_ready),
      .fin       (eng_fin),
      .fin_ack   (fin_ack),
      .res_data  (res_data),
      .res_status(res_status),
      .res_done  (res_done),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   mfb_store #(
      .DEPTH (STORE_BYTES),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign invert_in    = csr_wr_en ? csr_wr_data : invert_ff;
   assign blit_row_in  = (accept && plan.cnt_we) ? plan.blit_row  : blit_row_ff;
   assign blit_byte_in = (accept && plan.cnt_we) ? plan.blit_byte : blit_byte_ff;

   always_comb begin
      if (eng_fin && fin_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         blit_row_ff  <= '0;
         blit_byte_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         invert_ff    <= invert_in;
         blit_row_ff  <= blit_row_in;
         blit_byte_ff <= blit_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_fin && fin_ack) begin
         rsp_data_ff   <= res_data;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/mfb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Byte-wide memory with one write port and one registered read port. The read
// data register only updates when a read is issued, so it holds otherwise.
// ----------------------------------------------------------------------------
module mfb_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mfb_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command decoder
// Turns one request word into a plan for the byte engine: operation kind,
// first store address, byte count, masks and data, status and the next blit
// counter values. Clipping and all edge checks are settled here.
// ----------------------------------------------------------------------------
module mfb_plan import mfb_pkg::*; #(
   parameter  int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter  int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8,
   localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT,
   localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
   input  logic [2:0]             mode,
   input  logic [8:0]             x_pos,
   input  logic [7:0]             y_pos,
   input  logic [7:0]             y_end,
   input  logic [7:0]             blit_width,
   input  logic [6:0]             blit_height,
   input  logic [7:0]             source_byte,
   input  logic [9:0]             read_index,
   input  logic                   invert,
   input  logic [BLIT_ROW_W-1:0]  blit_row,
   input  logic [BLIT_BYTE_W-1:0] blit_byte,
   output plan_type               plan,
   output logic [ADDR_W-1:0]      plan_addr,
   output logic [ADDR_W-1:0]      plan_count
);

   localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam logic [9:0]        W_L         = 10'(SCREEN_WIDTH);
   localparam logic [8:0]        H_L         = 9'(SCREEN_HEIGHT);
   localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0] LAST_COL    = ADDR_W'(ROW_BYTES - 1);

   logic                    x_on;
   logic                    y_on;
   logic [5:0]              bpr;
   logic                    restart;
   logic [BLIT_BYTE_W-1:0]  bbr_e;
   logic [BLIT_ROW_W-1:0]   brow_e;
   logic [8:0]              py9;
   logic                    py_on;
   logic [9:0]              s10;
   logic [7:0]              m8;
   logic [7:0]              d8;
   logic [15:0]             m16;
   logic [15:0]             d16;
   logic [5:0]              nb6;
   logic [7:0]              nr8;
   logic signed [8:0]       lo9;
   logic signed [8:0]       hi9;
   logic signed [8:0]       span9;
   logic                    line_on;
   logic                    rd_on;
   logic [8:0]              rsel9;
   logic [ROW_W-1:0]        row_sel;
   logic [ADDR_W-1:0]       row_base;
   logic [7:0]              pix_mask;
   logic [7:0]              draw_byte;

   assign x_on = !x_pos[8] && ({2'b00, x_pos[7:0]} < W_L);
   assign y_on = !y_pos[7] && ({2'b00, y_pos[6:0]} < H_L);

   // Blit geometry: counters that no longer fit the bitmap restart the blit.
   assign bpr     = 6'(({1'b0, blit_width} + 9'd7) >> 3);
   assign restart = ({1'b0, blit_byte} >= bpr) || (blit_row >= blit_height);
   assign bbr_e   = restart ? '0 : blit_byte;
   assign brow_e  = restart ? '0 : blit_row;
   assign py9     = {2'b00, y_pos[6:0]} + {2'b00, brow_e};
   assign py_on   = py9 < H_L;
   assign s10     = {2'b00, x_pos[7:0]} + {2'b00, bbr_e, 3'b000};
   assign d8      = source_byte ^ {8{invert}};
   assign nb6     = {1'b0, bbr_e} + 6'd1;
   assign nr8     = {1'b0, brow_e} + 8'd1;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         m8[7 - b] = ({bbr_e, 3'(b)} < blit_width) && ((s10 + 10'(b)) < W_L) && py_on;
      end
   end

   assign m16 = {m8, 8'h00} >> x_pos[2:0];
   assign d16 = {d8, 8'h00} >> x_pos[2:0];

   // Vertical line, clipped to the screen rows.
   assign lo9     = y_pos[7] ? 9'sd0 : $signed({1'b0, y_pos});
   assign hi9     = (!y_end[7] && ({1'b0, y_end} >= H_L)) ? $signed(H_L - 9'd1)
                                                          : $signed({y_end[7], y_end});
   assign span9   = hi9 - lo9;
   assign line_on = x_on && !(lo9 > hi9);

   assign rd_on = 32'(read_index) < 32'(STORE_BYTES);

   // One row-address multiplier serves the blit, pixel and line modes.
   always_comb begin
      case (mode)
         MODE_BLIT:  rsel9 = py9;
         MODE_VLINE: rsel9 = lo9;
         default:    rsel9 = {2'b00, y_pos[6:0]};
      endcase
   end

   assign row_sel   = ROW_W'(rsel9);
   assign row_base  = ADDR_W'(row_sel) * ROW_BYTES_A;
   assign pix_mask  = PIXEL_MSB >> x_pos[2:0];
   assign draw_byte = invert ? 8'h00 : BYTE_ONES;

   always_comb begin
      plan            = '0;
      plan.kind       = OP_NONE;
      plan.blit_row   = blit_row;
      plan.blit_byte  = blit_byte;
      plan_addr       = '0;
      plan_count      = '0;
      case (mode)
         MODE_BLIT: begin
            if ((blit_width == 8'd0) || (blit_height == 7'd0)) begin
               plan.cnt_we    = 1'b1;
               plan.blit_row  = '0;
               plan.blit_byte = '0;
               plan.blit_done = 1'b1;
            end else if (!(x_on && y_on)) begin
               plan.status = 1'b1;
            end else begin
               plan.cnt_we = 1'b1;
               if (nb6 >= bpr) begin
                  plan.blit_byte = '0;
                  if (nr8 >= {1'b0, blit_height}) begin
                     plan.blit_row  = '0;
                     plan.blit_done = 1'b1;
                  end else begin
                     plan.blit_row = BLIT_ROW_W'(nr8);
                  end
               end else begin
                  plan.blit_byte = BLIT_BYTE_W'(nb6);
                  plan.blit_row  = brow_e;
               end
               // The first byte holds the leftmost pixel, so an empty first
               // mask means nothing of this word lands on screen.
               plan.kind  = (m16[15:8] != 8'h00) ? OP_RMW : OP_NONE;
               plan.mask  = m16;
               plan.data  = d16;
               plan_addr  = row_base + ADDR_W'(s10[9:3]);
               plan_count = (m16[7:0] != 8'h00) ? ADDR_W'(1) : '0;
            end
         end
         MODE_PIXEL: begin
            if (x_on && y_on) begin
               plan.kind = OP_RMW;
               plan.mask = {pix_mask, 8'h00};
               plan.data = {draw_byte, 8'h00};
               plan_addr = row_base + ADDR_W'(x_pos[7:3]);
            end else begin
               plan.status = 1'b1;
            end
         end
         MODE_VLINE: begin
            if (line_on) begin
               plan.kind     = OP_RMW;
               plan.row_step = 1'b1;
               plan.mask     = {pix_mask, 8'h00};
               plan.data     = {draw_byte, 8'h00};
               plan_addr     = row_base + ADDR_W'(x_pos[7:3]);
               plan_count    = ADDR_W'(span9);
            end else begin
               plan.status = 1'b1;
            end
         end
         MODE_HLINE: begin
            if (y_on) begin
               plan.kind  = OP_FILL;
               plan.data  = {draw_byte, 8'h00};
               plan_addr  = row_base;
               plan_count = LAST_COL;
            end else begin
               plan.status = 1'b1;
            end
         end
         MODE_CLEAR: begin
            plan.kind      = OP_FILL;
            plan.data      = {{8{invert}}, 8'h00};
            plan.cnt_we    = 1'b1;
            plan.blit_row  = '0;
            plan.blit_byte = '0;
            plan_count     = LAST_ADDR;
         end
         MODE_READ: begin
            if (rd_on) begin
               plan.kind = OP_READ;
               plan_addr = ADDR_W'(read_index);
            end else begin
               plan.status = 1'b1;
            end
         end
         default: begin
            plan.status = 1'b1;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mfb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte engine
// Small sequencer around one read-modify-write merge unit and an address
// walker. It runs the store clearing sweep after reset, fills, masked byte
// updates and single reads, then offers the result until it is taken.
// ----------------------------------------------------------------------------
module mfb_engine import mfb_pkg::*; #(
   parameter  int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter  int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8,
   localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT,
   localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  plan_type          plan,
   input  logic [ADDR_W-1:0] plan_addr,
   input  logic [ADDR_W-1:0] plan_count,
   output logic              ready,
   output logic              fin,
   input  logic              fin_ack,
   output logic [7:0]        res_data,
   output logic              res_status,
   output logic              res_done,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [7:0]        mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [7:0]        mem_rdata
);

   localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_BYTES - 1);

   typedef enum logic [6:0] {
      S_SWEEP  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_READ   = 7'b0000100,
      S_RMW_RD = 7'b0001000,
      S_RMW_WR = 7'b0010000,
      S_FILL   = 7'b0100000,
      S_DONE   = 7'b1000000
   } eng_state_type;

   eng_state_type     state_ff,    state_in;
   logic [ADDR_W-1:0] addr_ff,     addr_in;
   logic [ADDR_W-1:0] count_ff,    count_in;
   logic [15:0]       data_ff,     data_in;
   logic [15:0]       mask_ff,     mask_in;
   logic              row_step_ff, row_step_in;
   logic              status_ff,   status_in;
   logic              done_ff,     done_in;
   logic              rd_sel_ff,   rd_sel_in;
   logic [7:0]        merged;

   assign merged = (mem_rdata & ~mask_ff[15:8]) | (data_ff[15:8] & mask_ff[15:8]);

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      data_in     = data_ff;
      mask_in     = mask_ff;
      row_step_in = row_step_ff;
      status_in   = status_ff;
      done_in     = done_ff;
      rd_sel_in   = rd_sel_ff;
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wdata   = data_ff[15:8];
      mem_re      = 1'b0;
      mem_raddr   = addr_ff;
      case (state_ff)
         S_SWEEP, S_FILL: begin
            mem_we = 1'b1;
            if (count_ff == '0) begin
               state_in = (state_ff == S_SWEEP) ? S_IDLE : S_DONE;
            end else begin
               addr_in  = addr_ff + ADDR_W'(1);
               count_in = count_ff - ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               addr_in     = plan_addr;
               count_in    = plan_count;
               data_in     = plan.data;
               mask_in     = plan.mask;
               row_step_in = plan.row_step;
               status_in   = plan.status;
               done_in     = plan.blit_done;
               rd_sel_in   = (plan.kind == OP_READ);
               case (plan.kind)
                  OP_RMW:  state_in = S_RMW_RD;
                  OP_FILL: state_in = S_FILL;
                  OP_READ: state_in = S_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_DONE;
         end
         S_RMW_RD: begin
            mem_re   = 1'b1;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we    = 1'b1;
            mem_wdata = merged;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               count_in = count_ff - ADDR_W'(1);
               state_in = S_RMW_RD;
               // A vertical line steps down one row; a blit moves on to the
               // next byte of the same row with the second half of its masks.
               if (row_step_ff) begin
                  addr_in = addr_ff + ROW_BYTES_A;
               end else begin
                  addr_in = addr_ff + ADDR_W'(1);
                  mask_in = {mask_ff[7:0], 8'h00};
                  data_in = {data_ff[7:0], 8'h00};
               end
            end
         end
         S_DONE: begin
            if (fin_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The sweep after reset writes zeros through the whole store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         addr_ff  <= '0;
         count_ff <= LAST_ADDR;
         data_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         data_ff  <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      row_step_ff <= row_step_in;
      status_ff   <= status_in;
      done_ff     <= done_in;
      rd_sel_ff   <= rd_sel_in;
   end

   assign ready      = (state_ff == S_IDLE);
   assign fin        = (state_ff == S_DONE);
   assign res_data   = rd_sel_ff ? mem_rdata : 8'h00;
   assign res_status = status_ff;
   assign res_done   = done_ff;

endmodule

FILE: hw/rtl/mfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter port checker
// Watches the top level's ports over time and is bound to every instance of
// the top level.
// ----------------------------------------------------------------------------
module mfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled response word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // The engine leaves its idle state on an accept, so ready drops after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted twice in a row");

   // An ignored command never ends a blit and never returns store data.
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && (rsp_tdata == 8'h00))
      else $error("ignored command reported data or blit end");

   // The store is being cleared just after reset, so nothing is accepted.
   a_sweep_busy: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("block ready during the clearing sweep");

endmodule

bind mono_framebuffer_blitter_unit mfb_checker u_checker (.*);
